FILE: rtl/epw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epw_pkg
// Shared types and constants for the echo pulse width capture unit.
// ----------------------------------------------------------------------------
package epw_pkg;

  localparam int CHANNELS      = 2;
  localparam int PRESCALE_W    = 16;
  localparam int COUNT_W       = 16;
  localparam int WRAP_W        = 6;
  localparam int TIME_W        = WRAP_W + COUNT_W;
  localparam int DIST_W        = 17;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 16'd71;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 16'hFFFF;
  localparam logic [WRAP_W-1:0]     WRAP_MAX     = 6'h3F;

  // floor(t*17/1000) == (t * DIST_MULT) >> DIST_SHIFT for every 22-bit t
  localparam int                DIST_SHIFT = 32;
  localparam int                MULT_W     = 27;
  localparam int                PROD_W     = TIME_W + MULT_W;
  localparam logic [MULT_W-1:0] DIST_MULT  = 27'd73014445;

  typedef struct packed {
    logic echo_ch0;
    logic echo_ch1;
    logic clear_ch0;
    logic clear_ch1;
  } epw_in_t;

  typedef struct packed {
    logic              done_ch0;
    logic [TIME_W-1:0] time_ch0;
    logic [DIST_W-1:0] dist_ch0;
    logic              timeout_ch0;
    logic              done_ch1;
    logic [TIME_W-1:0] time_ch1;
    logic [DIST_W-1:0] dist_ch1;
    logic              timeout_ch1;
  } epw_out_t;

  // pipeline control from the top level to each lane
  typedef struct packed {
    logic accept;
    logic tick;
    logic s2_en;
  } epw_lane_ctl_t;

  // one channel's finished result
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] time_val;
    logic [DIST_W-1:0] dist_cm;
    logic              timeout;
  } epw_lane_res_t;

endpackage

FILE: rtl/epw_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epw_lane
// One capture channel: edge detect, tick counting, wrap and timeout handling,
// a result snapshot and a registered distance multiply.
// ----------------------------------------------------------------------------
module epw_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  epw_pkg::epw_lane_ctl_t ctl,
  input  logic                   echo,
  input  logic                   clear,
  output epw_pkg::epw_lane_res_t res
);

  logic [epw_pkg::COUNT_W-1:0] pulse_r, pulse_nxt;
  logic [epw_pkg::WRAP_W-1:0]  wrap_r, wrap_nxt;
  logic                        armed_r, armed_nxt;
  logic                        done_r, done_nxt;
  logic                        tmo_r, tmo_nxt;
  logic [epw_pkg::COUNT_W-1:0] held_r, held_nxt;
  logic                        last_r;

  logic rise, fall;

  // stage 1 snapshot
  logic                        s1_done_r, s1_tmo_r;
  logic [epw_pkg::TIME_W-1:0]  s1_time_r, s1_time_nxt;

  // stage 2
  logic                        s2_done_r, s2_tmo_r;
  logic [epw_pkg::TIME_W-1:0]  s2_time_r;
  logic [epw_pkg::DIST_W-1:0]  s2_dist_r;
  logic [epw_pkg::PROD_W-1:0]  prod;

  assign rise = echo & ~last_r;
  assign fall = ~echo & last_r;

  always_comb begin
    pulse_nxt = pulse_r;
    wrap_nxt  = wrap_r;
    armed_nxt = armed_r;
    done_nxt  = done_r;
    tmo_nxt   = tmo_r;
    held_nxt  = held_r;
    if (clear) begin
      pulse_nxt = '0;
      wrap_nxt  = '0;
      armed_nxt = 1'b0;
      done_nxt  = 1'b0;
      tmo_nxt   = 1'b0;
      held_nxt  = '0;
    end else if (done_r) begin
      // hold the finished measurement
    end else if (!armed_r) begin
      if (rise) begin
        armed_nxt = 1'b1;
        pulse_nxt = '0;
        wrap_nxt  = '0;
      end
    end else if (fall) begin
      done_nxt = 1'b1;
      held_nxt = pulse_r;
    end else if (ctl.tick) begin
      if (pulse_r == epw_pkg::COUNT_MAX) begin
        pulse_nxt = '0;
        if (wrap_r == epw_pkg::WRAP_MAX) begin
          done_nxt = 1'b1;
          tmo_nxt  = 1'b1;
          held_nxt = epw_pkg::COUNT_MAX;
        end else begin
          wrap_nxt = wrap_r + epw_pkg::WRAP_W'(1);
        end
      end else begin
        pulse_nxt = pulse_r + epw_pkg::COUNT_W'(1);
      end
    end
  end

  assign s1_time_nxt = done_nxt ? {wrap_nxt, held_nxt} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= '0;
      wrap_r  <= '0;
      armed_r <= 1'b0;
      done_r  <= 1'b0;
      tmo_r   <= 1'b0;
      held_r  <= '0;
      last_r  <= 1'b0;
    end else if (ctl.accept) begin
      pulse_r <= pulse_nxt;
      wrap_r  <= wrap_nxt;
      armed_r <= armed_nxt;
      done_r  <= done_nxt;
      tmo_r   <= tmo_nxt;
      held_r  <= held_nxt;
      last_r  <= echo;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_done_r <= done_nxt;
      s1_tmo_r  <= done_nxt & tmo_nxt;
      s1_time_r <= s1_time_nxt;
    end
  end

  assign prod = epw_pkg::PROD_W'(s1_time_r) * epw_pkg::PROD_W'(epw_pkg::DIST_MULT);

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      s2_done_r <= s1_done_r;
      s2_tmo_r  <= s1_tmo_r;
      s2_time_r <= s1_time_r;
      s2_dist_r <= prod[epw_pkg::DIST_SHIFT +: epw_pkg::DIST_W];
    end
  end

  assign res.done     = s2_done_r;
  assign res.time_val = s2_time_r;
  assign res.dist_cm  = s2_dist_r;
  assign res.timeout  = s2_tmo_r;

endmodule

FILE: rtl/epw_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epw_merge
// Output register: gathers the lane results into one result transfer.
// ----------------------------------------------------------------------------
module epw_merge (
  input  logic                   clk,
  input  logic                   load,
  input  epw_pkg::epw_lane_res_t lane_res [epw_pkg::CHANNELS],
  output epw_pkg::epw_out_t      out_data
);

  epw_pkg::epw_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.done_ch0    = lane_res[0].done;
    out_nxt.time_ch0    = lane_res[0].time_val;
    out_nxt.dist_ch0    = lane_res[0].dist_cm;
    out_nxt.timeout_ch0 = lane_res[0].timeout;
    out_nxt.done_ch1    = lane_res[1].done;
    out_nxt.time_ch1    = lane_res[1].time_val;
    out_nxt.dist_ch1    = lane_res[1].dist_cm;
    out_nxt.timeout_ch1 = lane_res[1].timeout;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/echo_pulse_width_capture_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_pulse_width_capture_unit
// Two-channel echo high-time capture with distance conversion.
//
// Each input transfer is one sample of both echo pins plus per-channel clear
// requests; each accepted input produces exactly one result transfer holding
// done, time in ticks, distance in cm and timeout for every channel, taken
// from the channel state after that sample. A shared prescaler advances once
// per accepted input and ticks every prescale+1 inputs.
// out_valid rises once the result has passed the state update and snapshot
// stage, the distance multiply stage and the output register, in that order.
// One item is accepted every cycle while out_stall does not hold the pipeline;
// each of the three stages takes a new item whenever the next one has room.
// cfg_wr_en loads the prescale register; write it only while idle.
// Reset (rst_n low at a clock edge) clears all channel state, the prescaler
// count and the pipeline, and loads prescale with 71.
// A stalled output holds its data; the input keeps being taken until the
// internal stages are full, then in_stall rises.
// ----------------------------------------------------------------------------
module echo_pulse_width_capture_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  epw_pkg::epw_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output epw_pkg::epw_out_t                   out_data,
  input  logic                                cfg_wr_en,
  input  logic [epw_pkg::PRESCALE_W-1:0]      cfg_wr_data
);

  logic [epw_pkg::PRESCALE_W-1:0] prescale_r, pcount_r, pcount_nxt;
  logic                           tick;

  logic s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, out_v_r, out_v_nxt;
  logic out_ready, s2_ready, s1_ready, s1_adv, s2_adv, accept;

  logic [epw_pkg::CHANNELS-1:0]   echo_vec, clear_vec;
  epw_pkg::epw_lane_ctl_t         lane_ctl;
  epw_pkg::epw_lane_res_t         lane_res [epw_pkg::CHANNELS];

  // pipeline handshake
  assign out_ready = ~out_v_r | ~out_stall;
  assign s2_adv    = s2_v_r & out_ready;
  assign s2_ready  = ~s2_v_r | out_ready;
  assign s1_adv    = s1_v_r & s2_ready;
  assign s1_ready  = ~s1_v_r | s2_ready;
  assign accept    = in_valid & s1_ready;
  assign in_stall  = ~s1_ready;

  assign s1_v_nxt  = accept | (s1_v_r & ~s1_adv);
  assign s2_v_nxt  = s1_adv | (s2_v_r & ~s2_adv);
  assign out_v_nxt = s2_adv | (out_v_r & out_stall);

  // prescaler: tick on match, then restart
  assign tick       = (pcount_r == prescale_r);
  assign pcount_nxt = tick ? '0 : pcount_r + epw_pkg::PRESCALE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= epw_pkg::PRESCALE_RST;
      pcount_r   <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prescale_r <= cfg_wr_data;
      end
      if (accept) begin
        pcount_r <= pcount_nxt;
      end
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign echo_vec  = {in_data.echo_ch1, in_data.echo_ch0};
  assign clear_vec = {in_data.clear_ch1, in_data.clear_ch0};

  assign lane_ctl.accept = accept;
  assign lane_ctl.tick   = tick;
  assign lane_ctl.s2_en  = s1_adv;

  for (genvar c = 0; c < epw_pkg::CHANNELS; c++) begin : g_lane
    epw_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .echo  (echo_vec[c]),
      .clear (clear_vec[c]),
      .res   (lane_res[c])
    );
  end

  epw_merge u_merge (
    .clk      (clk),
    .load     (s2_adv),
    .lane_res (lane_res),
    .out_data (out_data)
  );

  assign out_valid = out_v_r;

  // an empty output stage always leaves room for a new input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> !in_stall)
    else $error("input stalled while output stage empty");

  // a channel zero timeout result carries the saturated time
  a_timeout_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data.timeout_ch0 |->
      out_data.done_ch0 && out_data.time_ch0 == '1 && out_data.dist_ch0 == 17'd71303)
    else $error("channel zero timeout without saturated result");

  // an unfinished channel one reports zero time and distance
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_data.done_ch1 |->
      out_data.time_ch1 == '0 && out_data.dist_ch1 == '0 && !out_data.timeout_ch1)
    else $error("channel one reports data without done");

  // an accepted input always reaches stage one
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted input lost at stage one");

endmodule
